>>> sv/aat_pkg.sv
// Shared types and constants for the adaptive acceptance threshold block.
// No dependencies; used by every module of the block by scoped name.
package aat_pkg;

  localparam int DefMaxWindow = 32;

  localparam int CostW  = 32;
  localparam int QualW  = 16;
  localparam int WinW   = 6;
  localparam int CfgIdxW = 2;

  localparam logic [WinW-1:0]  WindowReset  = 6'd30;
  localparam logic [QualW-1:0] DecayReset   = 16'd58982;
  localparam logic [QualW-1:0] QualityReset = 16'd65535;

  typedef enum logic [CfgIdxW-1:0] {
    REG_WINDOW_SIZE     = 2'd0,
    REG_DECAY_FACTOR    = 2'd1,
    REG_INITIAL_QUALITY = 2'd2
  } cfg_reg_t;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_AVG  = 6'b000100,
    ST_DIFF = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

endpackage

>>> sv/adaptive_acceptance_threshold.sv
// Top level: cost ring as a chain of cells, divider and threshold datapath.
// Depends on aat_pkg, aat_cell and aat_div.
//
//   port group  dir   beat fields
//   in_*        in    cost
//   out_*       out   threshold_value, best_slot, best_value, reference_slot,
//                     accepted, written_slot
//   cfg_*       in    index, data (window_size, decay_factor, initial_quality)
//
// One item at a time: the next beat is taken only once the minimum search token has
// walked the cell chain and the bit-serial average divide has finished, which run side
// by side, and then four threshold steps have followed.
// Reset is synchronous, active low; no clearing pass.
// A finished result waits in the output register while the next beat is taken;
// only the final step of the next item stalls on a full output register.
module adaptive_acceptance_threshold #(
  parameter int MAX_WINDOW = aat_pkg::DefMaxWindow
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [aat_pkg::CostW-1:0]     in_cost,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [aat_pkg::CostW-1:0]     out_threshold_value,
  output logic [$clog2(MAX_WINDOW)-1:0] out_best_slot,
  output logic [aat_pkg::CostW-1:0]     out_best_value,
  output logic [$clog2(MAX_WINDOW)-1:0] out_reference_slot,
  output logic                          out_accepted,
  output logic [$clog2(MAX_WINDOW)-1:0] out_written_slot,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [aat_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [aat_pkg::CostW-1:0]     cfg_data
);

  localparam int SLOT_W = $clog2(MAX_WINDOW);
  localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
  localparam int CMP_W  = (CNT_W > aat_pkg::WinW) ? CNT_W : aat_pkg::WinW;
  localparam int CW     = aat_pkg::CostW;
  localparam int QW     = aat_pkg::QualW;

  // configuration
  logic [aat_pkg::WinW-1:0] window_r;
  logic [QW-1:0]            decay_r;

  // block state
  aat_pkg::state_t  state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [SLOT_W-1:0] oldest_r;
  logic [CW-1:0]     avg_r;
  logic [QW-1:0]     quality_r;
  logic [SLOT_W-1:0] ref_r;

  // per-item work registers
  logic [CW-1:0]     cost_r;
  logic [SLOT_W-1:0] slot_r;
  logic              avg_neg_r;
  logic              start_r;
  logic              scan_done_r;
  logic [CW-1:0]     best_v_r;
  logic [SLOT_W-1:0] best_i_r;
  logic              dneg_r;
  logic [CW-1:0]     dmag_r;
  logic [CW+QW-1:0]  prod_r;

  // output register
  logic              out_valid_r;
  logic [CW-1:0]     o_thr_r, o_best_v_r;
  logic [SLOT_W-1:0] o_best_i_r, o_ref_r, o_slot_r;
  logic              o_acc_r;

  logic in_fire, out_fire, load_out, q_load;

  assign in_ready  = (state_r == aat_pkg::ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign out_fire  = out_valid_r && out_ready;
  assign cfg_ready = 1'b1;
  // an initial_quality write takes priority over the per-beat decay
  assign q_load    = cfg_valid && cfg_ready && (cfg_index == aat_pkg::REG_INITIAL_QUALITY);

  // ---------------- slot selection at accept ----------------
  logic [CMP_W-1:0]  win_ext;
  logic [CNT_W-1:0]  w_eff, n0, n_nxt;
  logic [SLOT_W-1:0] slot_nxt, oldest_nxt, base_slot;
  logic [CNT_W-1:0]  inc_slot;

  always_comb begin
    win_ext = CMP_W'(window_r);
    if (win_ext == '0) begin
      w_eff = CNT_W'(1);
    end else if (win_ext > CMP_W'(MAX_WINDOW)) begin
      w_eff = CNT_W'(MAX_WINDOW);
    end else begin
      w_eff = CNT_W'(win_ext);
    end
    n0 = (cnt_r < w_eff) ? cnt_r : w_eff;
    base_slot = (CNT_W'(oldest_r) < w_eff) ? oldest_r : '0;
    inc_slot  = CNT_W'(base_slot) + CNT_W'(1);
    if (n0 < w_eff) begin
      slot_nxt   = n0[SLOT_W-1:0];
      n_nxt      = n0 + CNT_W'(1);
      oldest_nxt = oldest_r;
    end else begin
      slot_nxt   = base_slot;
      n_nxt      = n0;
      oldest_nxt = (inc_slot >= w_eff) ? '0 : inc_slot[SLOT_W-1:0];
    end
  end

  // ---------------- cell chain ----------------
  logic [MAX_WINDOW:0] tok_vld;
  logic [CW-1:0]       tok_cost [MAX_WINDOW+1];
  logic [SLOT_W-1:0]   tok_idx  [MAX_WINDOW+1];

  assign tok_vld[0]  = start_r;
  assign tok_cost[0] = '1;
  assign tok_idx[0]  = '0;

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    aat_cell #(
      .SLOT_W (SLOT_W),
      .CNT_W  (CNT_W),
      .IDX    (g)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .wr_en        (in_fire && (slot_nxt == SLOT_W'(g))),
      .wr_cost      (in_cost),
      .cnt          (cnt_r),
      .tok_in_vld   (tok_vld[g]),
      .tok_in_cost  (tok_cost[g]),
      .tok_in_idx   (tok_idx[g]),
      .tok_out_vld  (tok_vld[g+1]),
      .tok_out_cost (tok_cost[g+1]),
      .tok_out_idx  (tok_idx[g+1])
    );
  end

  // ---------------- running average divide ----------------
  logic [CW-1:0] div_q;
  logic          div_done;
  logic [CW-1:0] diff_mag;

  assign diff_mag = (in_cost < avg_r) ? (avg_r - in_cost) : (in_cost - avg_r);

  aat_div #(
    .VW (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire),
    .dividend (diff_mag),
    .divisor  (n_nxt),
    .quotient (div_q),
    .done     (div_done)
  );

  // ---------------- threshold datapath ----------------
  logic [31:0]      q_prod;
  logic [CW:0]      adj;
  logic [CW+QW:0]   prod_rnd;
  logic [CW+1:0]    t_wide;
  logic [CW-1:0]    thr;
  logic             acc;

  assign q_prod = quality_r * decay_r;

  always_comb begin
    prod_rnd = {1'b0, prod_r} + (CW+QW+1)'(16'hFFFF);
    // negative term rounds toward minus infinity
    adj = dneg_r ? prod_rnd[CW+QW:QW] : {1'b0, prod_r[CW+QW-1:QW]};
    t_wide = dneg_r ? ({2'b00, best_v_r} - {1'b0, adj})
                    : ({2'b00, best_v_r} + {1'b0, adj});
    if (t_wide[CW+1]) begin
      thr = '0;
    end else if (t_wide[CW]) begin
      thr = '1;
    end else begin
      thr = t_wide[CW-1:0];
    end
    acc = (cost_r < thr);
  end

  assign load_out = (state_r == aat_pkg::ST_FIN) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      aat_pkg::ST_IDLE: if (in_fire) state_nxt = aat_pkg::ST_SCAN;
      aat_pkg::ST_SCAN: if (scan_done_r && div_done) state_nxt = aat_pkg::ST_AVG;
      aat_pkg::ST_AVG:  state_nxt = aat_pkg::ST_DIFF;
      aat_pkg::ST_DIFF: state_nxt = aat_pkg::ST_MUL;
      aat_pkg::ST_MUL:  state_nxt = aat_pkg::ST_FIN;
      aat_pkg::ST_FIN:  if (load_out) state_nxt = aat_pkg::ST_IDLE;
      default:          state_nxt = aat_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aat_pkg::ST_IDLE;
      window_r    <= aat_pkg::WindowReset;
      decay_r     <= aat_pkg::DecayReset;
      quality_r   <= aat_pkg::QualityReset;
      cnt_r       <= '0;
      oldest_r    <= '0;
      avg_r       <= '0;
      ref_r       <= '0;
      start_r     <= 1'b0;
      scan_done_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= in_fire;
      if (in_fire) begin
        cnt_r       <= n_nxt;
        oldest_r    <= oldest_nxt;
        scan_done_r <= 1'b0;
      end else if (tok_vld[MAX_WINDOW]) begin
        scan_done_r <= 1'b1;
      end
      if (q_load) begin
        quality_r <= cfg_data[QW-1:0];
      end else if (in_fire) begin
        quality_r <= q_prod[31:16];
      end
      if (state_r == aat_pkg::ST_AVG) begin
        avg_r <= avg_neg_r ? (avg_r - div_q) : (avg_r + div_q);
      end
      if (load_out && acc) begin
        ref_r <= slot_r;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_fire) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          aat_pkg::REG_WINDOW_SIZE:  window_r <= cfg_data[aat_pkg::WinW-1:0];
          aat_pkg::REG_DECAY_FACTOR: decay_r  <= cfg_data[QW-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cost_r    <= in_cost;
      slot_r    <= slot_nxt;
      avg_neg_r <= (in_cost < avg_r);
    end
    if (tok_vld[MAX_WINDOW]) begin
      best_v_r <= tok_cost[MAX_WINDOW];
      best_i_r <= tok_idx[MAX_WINDOW];
    end
    if (state_r == aat_pkg::ST_DIFF) begin
      dneg_r <= (avg_r < best_v_r);
      dmag_r <= (avg_r < best_v_r) ? (best_v_r - avg_r) : (avg_r - best_v_r);
    end
    if (state_r == aat_pkg::ST_MUL) begin
      prod_r <= quality_r * dmag_r;
    end
    if (load_out) begin
      o_thr_r    <= thr;
      o_best_v_r <= best_v_r;
      o_best_i_r <= best_i_r;
      o_ref_r    <= acc ? slot_r : ref_r;
      o_acc_r    <= acc;
      o_slot_r   <= slot_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_threshold_value = o_thr_r;
  assign out_best_slot       = o_best_i_r;
  assign out_best_value      = o_best_v_r;
  assign out_reference_slot  = o_ref_r;
  assign out_accepted        = o_acc_r;
  assign out_written_slot    = o_slot_r;

  // ---------------- checks ----------------
  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld[MAX_WINDOW:1]))
    else $error("more than one search token in the cell chain");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again while an item is in flight");

  a_ref_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_accepted |-> out_reference_slot == out_written_slot)
    else $error("accepted cost did not move the reference slot");

  a_scan_before_avg: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == aat_pkg::ST_AVG |-> scan_done_r && div_done)
    else $error("average step began before search and divide finished");

endmodule

>>> sv/aat_cell.sv
// One slot of the cost ring plus its stage of the minimum-search chain.
// Uses aat_pkg for the cost width.
module aat_cell #(
  parameter int SLOT_W = 5,
  parameter int CNT_W  = 6,
  parameter int IDX    = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [aat_pkg::CostW-1:0]  wr_cost,
  input  logic [CNT_W-1:0]           cnt,
  input  logic                       tok_in_vld,
  input  logic [aat_pkg::CostW-1:0]  tok_in_cost,
  input  logic [SLOT_W-1:0]          tok_in_idx,
  output logic                       tok_out_vld,
  output logic [aat_pkg::CostW-1:0]  tok_out_cost,
  output logic [SLOT_W-1:0]          tok_out_idx
);

  localparam bit First = (IDX == 0);

  logic [aat_pkg::CostW-1:0] cost_r;
  logic                      vld_r;
  logic [aat_pkg::CostW-1:0] tcost_r;
  logic [SLOT_W-1:0]         tidx_r;
  logic                      take_own;

  // slot 0 always seeds the search; later slots win only on strictly lower cost
  assign take_own = (CNT_W'(IDX) < cnt) && (First || (cost_r < tok_in_cost));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      cost_r <= wr_cost;
    end
    tcost_r <= take_own ? cost_r : tok_in_cost;
    tidx_r  <= take_own ? SLOT_W'(IDX) : tok_in_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= tok_in_vld;
    end
  end

  assign tok_out_vld  = vld_r;
  assign tok_out_cost = tcost_r;
  assign tok_out_idx  = tidx_r;

endmodule

>>> sv/aat_div.sv
// Restoring divider, one quotient bit per cycle, for the running-average step.
// Uses aat_pkg for the dividend width.
module aat_div #(
  parameter int VW = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [aat_pkg::CostW-1:0] dividend,
  input  logic [VW-1:0]             divisor,
  output logic [aat_pkg::CostW-1:0] quotient,
  output logic                      done
);

  localparam int DW   = aat_pkg::CostW;
  localparam int CW   = $clog2(DW + 1);

  logic [DW-1:0] a_r, a_nxt;
  logic [VW-1:0] rem_r, rem_nxt;
  logic [VW-1:0] div_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [VW:0]   trial;
  logic          qbit;

  always_comb begin
    trial   = {rem_r, a_r[DW-1]};
    qbit    = (trial >= {1'b0, div_r});
    rem_nxt = qbit ? VW'(trial - {1'b0, div_r}) : trial[VW-1:0];
    a_nxt   = {a_r[DW-2:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      a_r   <= a_nxt;
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CW'(DW - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  assign quotient = a_r;
  assign done     = done_r;

endmodule

>>> dv/testbench.sv
// Self-checking testbench for adaptive_acceptance_threshold: random and directed costs,
// register sweeps between phases, and a scoreboard fed by a per-item predictor.
// Depends on aat_pkg and the adaptive_acceptance_threshold RTL.
module testbench;

  localparam int CostW = aat_pkg::CostW;
  localparam int QualW = aat_pkg::QualW;
  localparam int WinW = aat_pkg::WinW;
  localparam int CfgIdxW = aat_pkg::CfgIdxW;
  localparam int MaxWin = aat_pkg::DefMaxWindow;
  localparam int SlotW = $clog2(aat_pkg::DefMaxWindow);
  localparam int CycleLimit = 1000000;
  localparam int SettleCycles = 48;
  localparam int NumPhases = 16;
  localparam int PhaseItems = 102;
  localparam logic [CfgIdxW-1:0] RegBeyondList = 2'd3;

  typedef struct packed {
    logic [CostW-1:0] threshold;
    logic [SlotW-1:0] best_slot;
    logic [CostW-1:0] best_value;
    logic [SlotW-1:0] ref_slot;
    logic             accepted;
    logic [SlotW-1:0] written_slot;
  } verdict_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [CostW-1:0]     in_cost = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [CostW-1:0]     out_threshold_value;
  logic [SlotW-1:0]     out_best_slot;
  logic [CostW-1:0]     out_best_value;
  logic [SlotW-1:0]     out_reference_slot;
  logic                 out_accepted;
  logic [SlotW-1:0]     out_written_slot;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index = '0;
  logic [CostW-1:0]     cfg_data = '0;

  adaptive_acceptance_threshold dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_cost(in_cost),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_threshold_value(out_threshold_value), .out_best_slot(out_best_slot),
    .out_best_value(out_best_value), .out_reference_slot(out_reference_slot),
    .out_accepted(out_accepted), .out_written_slot(out_written_slot),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial forever #6 clk = ~clk;

  // predictor state
  logic [CostW-1:0] ring [MaxWin];
  int unsigned      kept, oldest;
  logic [CostW-1:0] avg;
  logic [QualW-1:0] quality;
  logic [SlotW-1:0] ref_idx;
  logic [WinW-1:0]  win_reg;
  logic [QualW-1:0] decay_reg, init_q_reg;

  logic [CostW-1:0] cost_backlog [$];
  verdict_t         verdicts_due [$];
  int               mismatches = 0;
  int               cycle_count = 0;
  logic             in_took = 1'b0;
  bit               send_idle = 1'b1, recv_idle = 1'b1;
  int               send_gap = 0, recv_stall = 0;

  function automatic void reset_predictor();
    foreach (ring[k]) ring[k] = '0;
    kept = 0;
    oldest = 0;
    avg = '0;
    win_reg = aat_pkg::WindowReset;
    decay_reg = aat_pkg::DecayReset;
    init_q_reg = aat_pkg::QualityReset;
    quality = aat_pkg::QualityReset;
    ref_idx = '0;
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CostW-1:0] data);
    case (idx)
      aat_pkg::REG_WINDOW_SIZE: win_reg = data[WinW-1:0];
      aat_pkg::REG_DECAY_FACTOR: decay_reg = data[QualW-1:0];
      aat_pkg::REG_INITIAL_QUALITY: begin
        init_q_reg = data[QualW-1:0];
        quality = data[QualW-1:0];
      end
      default: ;
    endcase
  endfunction

  function automatic verdict_t advance_threshold(input logic [CostW-1:0] cost);
    int unsigned w, n, slot, best_i, k;
    logic [CostW-1:0] best_v;
    longint diff, t;
    logic [63:0] mag;
    verdict_t v;
    w = win_reg;
    if (w < 1) w = 1;
    if (w > MaxWin) w = MaxWin;
    n = (kept < w) ? kept : w;
    if (n < w) begin
      slot = n;
      n++;
    end else begin
      slot = (oldest < w) ? oldest : 0;
      oldest = slot + 1;
      if (oldest >= w) oldest = 0;
    end
    ring[slot] = cost;
    kept = n;

    best_i = 0;
    best_v = ring[0];
    for (k = 1; k < n; k++) begin
      if (ring[k] < best_v) begin
        best_v = ring[k];
        best_i = k;
      end
    end

    mag = ({48'd0, quality} * {48'd0, decay_reg}) >> 16;
    quality = mag[QualW-1:0];

    // truncating signed divide moves the average toward the new cost
    diff = longint'({32'd0, cost}) - longint'({32'd0, avg});
    avg = 32'(longint'({32'd0, avg}) + diff / longint'(n));

    diff = longint'({32'd0, avg}) - longint'({32'd0, best_v});
    if (diff >= 0) begin
      mag = {48'd0, quality} * 64'(diff);
      t = longint'({32'd0, best_v}) + longint'(mag >> 16);
    end else begin
      // floor of a negative product: round the magnitude up
      mag = {48'd0, quality} * 64'(-diff);
      t = longint'({32'd0, best_v}) - longint'((mag + 64'd65535) >> 16);
    end
    if (t < 0) t = 0;
    if (t > longint'(32'hFFFF_FFFF)) t = longint'(32'hFFFF_FFFF);

    v.accepted = longint'({32'd0, cost}) < t;
    if (v.accepted) ref_idx = slot[SlotW-1:0];
    v.threshold = t[CostW-1:0];
    v.best_slot = best_i[SlotW-1:0];
    v.best_value = best_v;
    v.ref_slot = ref_idx;
    v.written_slot = slot[SlotW-1:0];
    return v;
  endfunction

  function automatic void check_field(input string name, input logic [CostW-1:0] exp_v,
                                      input logic [CostW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // monitor: register writes, accepted costs and result beats
  always @(posedge clk) begin : watch
    verdict_t v;
    in_took <= in_valid && in_ready;
    if (!rst_n) begin
      reset_predictor();
    end else begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          v = verdicts_due.pop_front();
          check_field("threshold_value", v.threshold, out_threshold_value);
          check_field("best_slot", 32'(v.best_slot), 32'(out_best_slot));
          check_field("best_value", v.best_value, out_best_value);
          check_field("reference_slot", 32'(v.ref_slot), 32'(out_reference_slot));
          check_field("accepted", 32'(v.accepted), 32'(out_accepted));
          check_field("written_slot", 32'(v.written_slot), 32'(out_written_slot));
        end
      end
      if (in_valid && in_ready) verdicts_due = {verdicts_due, advance_threshold(in_cost)};
    end
  end

  // cost driver
  always @(negedge clk) begin : drive_in
    logic nv;
    logic [CostW-1:0] nc;
    nv = in_valid;
    nc = in_cost;
    if (!in_valid || in_took) begin
      nv = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
      end else if (send_idle && $urandom_range(0, 4) == 0) begin
        send_gap = $urandom_range(0, 3);
      end else if (cost_backlog.size() > 0) begin
        nv = 1'b1;
        nc = cost_backlog.pop_front();
      end
    end
    in_valid <= nv;
    in_cost <= nc;
  end

  // result receiver
  always @(negedge clk) begin : drive_out
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (recv_stall > 0) begin
      recv_stall--;
      out_ready <= 1'b0;
    end else if (recv_idle && $urandom_range(0, 4) == 0) begin
      recv_stall = $urandom_range(0, 3);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CostW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stimulus holds off here until every queued cost is sent and every result is back
  task automatic drain();
    while (cost_backlog.size() != 0 || in_valid || verdicts_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin : timeout
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAIL adaptive_acceptance_threshold");
    $finish;
  end

  initial begin : stimulus
    logic [CostW-1:0] junk, level, c;
    int p, k;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset configuration: extremes, ties, a descending run
    cost_backlog = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'hFFFF_FFFE, 32'h100, 32'h100,
                     32'h8000_0000, 32'h7FFF_FFFF, 32'h1_0000, 32'hFF, 32'hFE, 32'h0};
    drain();

    // out-of-range index is ignored; single-slot window with junk in upper data bits
    junk = $urandom;
    write_reg(RegBeyondList, junk);
    junk = $urandom;
    junk[WinW-1:0] = 6'd1;
    write_reg(aat_pkg::REG_WINDOW_SIZE, junk);
    junk = $urandom;
    junk[QualW-1:0] = 16'd0;
    write_reg(aat_pkg::REG_DECAY_FACTOR, junk);
    junk = $urandom;
    junk[QualW-1:0] = 16'hFFFF;
    write_reg(aat_pkg::REG_INITIAL_QUALITY, junk);
    cost_backlog = '{32'd5, 32'd0, 32'hFFFF_FFFF, 32'd7};
    drain();

    // zero window acts as one
    write_reg(aat_pkg::REG_WINDOW_SIZE, 32'd0);
    cost_backlog = '{32'h1234_5678, 32'h10, 32'h20};
    drain();

    // window above the maximum clamps; full decay, zero quality
    write_reg(aat_pkg::REG_WINDOW_SIZE, 32'd63);
    write_reg(aat_pkg::REG_DECAY_FACTOR, 32'hFFFF);
    write_reg(aat_pkg::REG_INITIAL_QUALITY, 32'd0);
    cost_backlog = '{32'h400, 32'h300, 32'h500, 32'h300};
    drain();

    for (p = 0; p < NumPhases; p++) begin
      send_idle = (p < NumPhases - 2) && ($urandom_range(0, 3) != 0);
      recv_idle = (p < NumPhases - 2) && ($urandom_range(0, 3) != 0);

      junk = $urandom;
      case ($urandom_range(0, 7))
        0: junk[WinW-1:0] = 6'd0;
        1: junk[WinW-1:0] = 6'd1;
        2: junk[WinW-1:0] = 6'd32;
        3: junk[WinW-1:0] = 6'($urandom_range(33, 63));
        4: junk[WinW-1:0] = 6'd2;
        default: junk[WinW-1:0] = 6'($urandom_range(1, 32));
      endcase
      write_reg(aat_pkg::REG_WINDOW_SIZE, junk);

      junk = $urandom;
      case ($urandom_range(0, 5))
        0: junk[QualW-1:0] = 16'd0;
        1: junk[QualW-1:0] = 16'hFFFF;
        2, 3: junk[QualW-1:0] = 16'($urandom_range(50000, 65535));
        default: ;
      endcase
      write_reg(aat_pkg::REG_DECAY_FACTOR, junk);

      if ($urandom_range(0, 1) == 0) begin
        junk = $urandom;
        case ($urandom_range(0, 3))
          0: junk[QualW-1:0] = 16'd0;
          1: junk[QualW-1:0] = 16'hFFFF;
          default: ;
        endcase
        write_reg(aat_pkg::REG_INITIAL_QUALITY, junk);
      end

      level = $urandom >> $urandom_range(0, 24);
      for (k = 0; k < PhaseItems; k++) begin
        case ($urandom_range(0, 9))
          0, 1: c = $urandom;
          2: c = ($urandom_range(0, 2) == 0) ? 32'd0 :
                 (($urandom_range(0, 1) == 0) ? 32'hFFFF_FFFF : level);
          3, 4: begin
            // improving search: cost creeps down
            level = level - (level >> 5) - 32'($urandom_range(0, 3));
            c = level;
          end
          default: c = level + 32'($urandom_range(0, 4095)) - 32'd2048;
        endcase
        cost_backlog = {cost_backlog, c};
      end
      drain();
    end

    if (mismatches == 0) begin
      $display("PASS adaptive_acceptance_threshold");
    end else begin
      $display("FAIL adaptive_acceptance_threshold");
    end
    $finish;
  end

endmodule

>>> adaptive_acceptance_threshold.f
sv/aat_pkg.sv
sv/aat_cell.sv
sv/aat_div.sv
sv/adaptive_acceptance_threshold.sv
dv/testbench.sv
